@@ hdl/circuit_breaker_table_macros.svh @@
// Assertion macros for the circuit breaker table RTL.
`ifndef CIRCUIT_BREAKER_TABLE_MACROS_SVH
`define CIRCUIT_BREAKER_TABLE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CBT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CBT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/cbt_pkg.sv @@
// Types, codes and helpers shared by the circuit breaker table modules.
package cbt_pkg;

  localparam int COUNT_W = 16;
  localparam int CFG_W   = 32;

  typedef logic [COUNT_W-1:0] count_t;

  localparam count_t COUNT_MAX = '1;

  typedef enum logic [1:0] {
    MODE_CLOSED = 2'd0,
    MODE_OPEN   = 2'd1,
    MODE_HALF   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ACT_FAIL    = 2'd0,
    ACT_SUCCESS = 2'd1,
    ACT_QUERY   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    REG_FAIL_LIMIT    = 2'd0,
    REG_SUCCESS_LIMIT = 2'd1,
    REG_RECOVERY_WAIT = 2'd2
  } reg_index_t;

  typedef struct packed {
    mode_t  mode;
    count_t fails;
    count_t successes;
  } brk_state_t;

  localparam int STATE_W = $bits(brk_state_t);

  typedef struct packed {
    logic       skip;
    brk_state_t state;
  } step_res_t;

  function automatic count_t sat_inc(count_t v);
    count_t r;
    r = (v == COUNT_MAX) ? v : count_t'(v + 1'b1);
    return r;
  endfunction

endpackage

@@ hdl/cbt_mem.sv @@
// Synchronous single-write, single-read memory with a registered read port.
module cbt_mem #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/cbt_step.sv @@
// Next-state logic of one breaker entry for one word.
module cbt_step #(
  parameter int TIME_BITS = 48
) (
  input  logic [1:0]               action,
  input  cbt_pkg::brk_state_t      cur,
  input  logic [TIME_BITS-1:0]     last_time,
  input  logic [TIME_BITS-1:0]     now_ms,
  input  cbt_pkg::count_t          fail_limit,
  input  cbt_pkg::count_t          success_limit,
  input  logic [cbt_pkg::CFG_W-1:0] recovery_wait,
  output cbt_pkg::step_res_t       res,
  output logic [TIME_BITS-1:0]     time_next
);

  localparam int CMP_W = (TIME_BITS > cbt_pkg::CFG_W) ? TIME_BITS : cbt_pkg::CFG_W;

  cbt_pkg::count_t      fails_inc;
  cbt_pkg::count_t      succ_inc;
  logic [TIME_BITS-1:0] elapsed;
  logic                 recovered;

  assign fails_inc = cbt_pkg::sat_inc(cur.fails);
  assign succ_inc  = cbt_pkg::sat_inc(cur.successes);
  assign elapsed   = now_ms - last_time;
  assign recovered = CMP_W'(elapsed) >= CMP_W'(recovery_wait);

  always_comb begin
    res.skip  = 1'b0;
    res.state = cur;
    time_next = last_time;
    case (action)
      cbt_pkg::ACT_FAIL: begin
        time_next = now_ms;
        if (cur.mode == cbt_pkg::MODE_HALF) begin
          res.state = '{cbt_pkg::MODE_OPEN, '0, '0};
        end else begin
          res.state.fails = fails_inc;
          if (fails_inc >= fail_limit) begin
            res.state.mode = cbt_pkg::MODE_OPEN;
          end
        end
      end
      cbt_pkg::ACT_SUCCESS: begin
        if (cur.mode == cbt_pkg::MODE_HALF) begin
          if (succ_inc >= success_limit) begin
            res.state = '{cbt_pkg::MODE_CLOSED, '0, '0};
          end else begin
            res.state.successes = succ_inc;
          end
        end else begin
          res.state.fails = '0;
        end
      end
      cbt_pkg::ACT_QUERY: begin
        if (cur.mode == cbt_pkg::MODE_OPEN) begin
          if (recovered) begin
            res.state = '{cbt_pkg::MODE_HALF, '0, '0};
          end else begin
            res.skip = 1'b1;
          end
        end
      end
      default: begin
        // The unused action code leaves the entry as it stands.
      end
    endcase
  end

endmodule

@@ hdl/circuit_breaker_table.sv @@
// Top level of the circuit breaker table: pipeline control, registers, memories.
//
// A table of METHODS circuit breakers kept in two synchronous memories (counts and mode in
// one, last failure time in the other). Each accepted word is a read-modify-write of one
// entry. The memory read is launched at the accepting edge. The update and write-back
// follow in the update stage, and the result word is registered at the same edge as the
// write-back; a stalled result holds the word in that stage. One word is accepted per
// cycle while the result is not stalled; a write-back to the entry that the next word
// reads is forwarded, so back-to-back words on the same method see each other. After reset
// the table clears every entry with item_stall held high; configuration writes are taken
// throughout. An index at or above METHODS leaves the table untouched and returns zeros.
`include "circuit_breaker_table_macros.svh"

module circuit_breaker_table #(
  parameter int METHODS   = 64,
  parameter int TIME_BITS = 48
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [cbt_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic [1:0]                  action,
  input  logic [5:0]                  method_index,
  input  logic [TIME_BITS-1:0]        now_ms,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic                        skip,
  output logic [1:0]                  mode_after,
  output logic [cbt_pkg::COUNT_W-1:0] fails_after,
  output logic [cbt_pkg::COUNT_W-1:0] successes_after
);

  localparam int IDX_W = (METHODS > 1) ? $clog2(METHODS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(METHODS - 1);

  cbt_pkg::count_t               fail_limit;
  cbt_pkg::count_t               success_limit;
  logic [cbt_pkg::CFG_W-1:0]     recovery_wait;

  logic                          clearing;
  logic [IDX_W-1:0]              clear_idx;

  logic                          accept;
  logic                          in_range;
  logic [IDX_W-1:0]              item_addr;

  logic                          s1_valid;
  logic                          s1_adv;
  logic [1:0]                    s1_action;
  logic [IDX_W-1:0]              s1_addr;
  logic                          s1_in_range;
  logic [TIME_BITS-1:0]          s1_now;

  logic                          fwd;
  cbt_pkg::brk_state_t           fwd_state;
  logic [TIME_BITS-1:0]          fwd_time;

  logic [cbt_pkg::STATE_W-1:0]   state_rd;
  logic [TIME_BITS-1:0]          time_rd;
  cbt_pkg::brk_state_t           cur_state;
  logic [TIME_BITS-1:0]          cur_time;

  cbt_pkg::step_res_t            res;
  logic [TIME_BITS-1:0]          time_next;

  logic                          mem_we;
  logic [IDX_W-1:0]              mem_waddr;
  logic [cbt_pkg::STATE_W-1:0]   state_wdata;
  logic [TIME_BITS-1:0]          time_wdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fail_limit    <= cbt_pkg::count_t'(5);
      success_limit <= cbt_pkg::count_t'(3);
      recovery_wait <= cbt_pkg::CFG_W'(5000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        cbt_pkg::REG_FAIL_LIMIT:    fail_limit    <= cfg_data[cbt_pkg::COUNT_W-1:0];
        cbt_pkg::REG_SUCCESS_LIMIT: success_limit <= cfg_data[cbt_pkg::COUNT_W-1:0];
        cbt_pkg::REG_RECOVERY_WAIT: recovery_wait <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Clearing pass after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clear_idx <= '0;
    end else if (clearing) begin
      clear_idx <= clear_idx + 1'b1;
      if (clear_idx == LAST_IDX) begin
        clearing <= 1'b0;
      end
    end
  end

  assign s1_adv     = s1_valid && (!result_valid || !result_stall);
  assign item_stall = clearing || (s1_valid && !s1_adv);
  assign accept     = item_valid && !item_stall;
  assign in_range   = 13'(method_index) < 13'(METHODS);
  assign item_addr  = IDX_W'(method_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // The write-back of the word leaving the update stage lands at the same edge as the
  // next read, so a hit on the same entry takes the fresh value from here instead.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action   <= action;
      s1_addr     <= item_addr;
      s1_in_range <= in_range;
      s1_now      <= now_ms;
      fwd         <= s1_adv && s1_in_range && (s1_addr == item_addr);
      fwd_state   <= res.state;
      fwd_time    <= time_next;
    end
  end

  cbt_mem #(
    .WIDTH (cbt_pkg::STATE_W),
    .DEPTH (METHODS),
    .AW    (IDX_W)
  ) u_state_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (state_wdata),
    .re    (accept),
    .raddr (item_addr),
    .rdata (state_rd)
  );

  cbt_mem #(
    .WIDTH (TIME_BITS),
    .DEPTH (METHODS),
    .AW    (IDX_W)
  ) u_time_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (time_wdata),
    .re    (accept),
    .raddr (item_addr),
    .rdata (time_rd)
  );

  assign cur_state = fwd ? fwd_state : cbt_pkg::brk_state_t'(state_rd);
  assign cur_time  = fwd ? fwd_time : time_rd;

  cbt_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .action        (s1_action),
    .cur           (cur_state),
    .last_time     (cur_time),
    .now_ms        (s1_now),
    .fail_limit    (fail_limit),
    .success_limit (success_limit),
    .recovery_wait (recovery_wait),
    .res           (res),
    .time_next     (time_next)
  );

  assign mem_we      = clearing || (s1_adv && s1_in_range);
  assign mem_waddr   = clearing ? clear_idx : s1_addr;
  assign state_wdata = clearing ? '0 : res.state;
  assign time_wdata  = clearing ? '0 : time_next;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (s1_in_range) begin
        skip            <= res.skip;
        mode_after      <= res.state.mode;
        fails_after     <= res.state.fails;
        successes_after <= res.state.successes;
      end else begin
        skip            <= 1'b0;
        mode_after      <= cbt_pkg::MODE_CLOSED;
        fails_after     <= '0;
        successes_after <= '0;
      end
    end
  end

  `CBT_ASSERT_NOW(a_no_work_while_clearing, clk, rst, s1_valid, !clearing,
                  "word in flight during clearing pass")
  `CBT_ASSERT_NEXT(a_accept_fills_stage, clk, rst, accept, s1_valid,
                   "accepted word lost before update stage")
  `CBT_ASSERT_NOW(a_skip_only_open, clk, rst, result_valid && skip,
                  mode_after == cbt_pkg::MODE_OPEN, "skip reported for a breaker that is not open")
  `CBT_ASSERT_NOW(a_successes_only_half, clk, rst,
                  result_valid && (mode_after != cbt_pkg::MODE_HALF),
                  successes_after == '0, "success count outside half-open")

endmodule
